// ===== sv/smsnp_pkg.sv =====
// ----------------------------------------------------------------------------
// smsnp_pkg
// Shared types, constants and the microcode table of the SMS notice parser.
// ----------------------------------------------------------------------------
package smsnp_pkg;

    localparam int NUMBER_CHARS = 13;
    localparam int PREFIX_DROP  = 3;
    localparam int MAX_EMIT     = 10;

    // number of characters emitted on completion
    localparam int EMIT_N = (NUMBER_CHARS - PREFIX_DROP < 0) ? 0 :
                            (NUMBER_CHARS - PREFIX_DROP > MAX_EMIT) ? MAX_EMIT :
                            (NUMBER_CHARS - PREFIX_DROP);
    localparam logic [3:0] EMIT_LAST = 4'((EMIT_N > 0) ? (EMIT_N - 1) : 0);

    localparam int CNT_W = $clog2(NUMBER_CHARS + 1);
    localparam int IDX_W = $clog2(NUMBER_CHARS);

    localparam logic [7:0] NL_BYTE   = 8'h0A;
    localparam logic [7:0] QUOTE     = 8'h22;
    localparam int         CMD_LEN   = 5;
    localparam logic [7:0] CMD_WORD [CMD_LEN] = '{8'h74, 8'h72, 8'h61, 8'h63, 8'h6B};

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_NUMBER = 2'd1,
        PH_SKIP   = 2'd2,
        PH_TEXT   = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FETCH,
        OP_WAIT,
        OP_NUMBER,
        OP_SKIP,
        OP_TEXT,
        OP_EMIT,
        OP_CLEAR
    } t_uop;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_PHASE,
        C_IS_LF,
        C_EMIT_DONE
    } t_jcond;

    localparam int STEP_W = 3;

    localparam logic [STEP_W-1:0] S_FETCH    = 3'd0;
    localparam logic [STEP_W-1:0] S_DISPATCH = 3'd1;
    localparam logic [STEP_W-1:0] S_WAIT     = 3'd2;
    localparam logic [STEP_W-1:0] S_NUMBER   = 3'd3;
    localparam logic [STEP_W-1:0] S_SKIP     = 3'd4;
    localparam logic [STEP_W-1:0] S_TEXT     = 3'd5;
    localparam logic [STEP_W-1:0] S_EMIT     = 3'd6;
    localparam logic [STEP_W-1:0] S_CLEAR    = 3'd7;

    localparam logic [STEP_W-1:0] S_AFTER_LF = (EMIT_N > 0) ? S_EMIT : S_CLEAR;

    typedef struct packed {
        t_uop              op;
        t_jcond            cond;
        logic [STEP_W-1:0] tgt_t;
        logic [STEP_W-1:0] tgt_f;
    } t_uword;

    typedef struct packed {
        t_uop op;
        logic accept;
    } t_ctrl;

    typedef struct packed {
        t_phase phase;
        logic   is_lf;
        logic   emit_done;
    } t_stat;

    // microcode table; the phase dispatch adds the phase to tgt_t
    function automatic t_uword ucode_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            S_FETCH:    w = '{OP_FETCH,  C_IN_VALID,  S_DISPATCH, S_FETCH};
            S_DISPATCH: w = '{OP_NONE,   C_PHASE,     S_WAIT,     S_WAIT};
            S_WAIT:     w = '{OP_WAIT,   C_ALWAYS,    S_FETCH,    S_FETCH};
            S_NUMBER:   w = '{OP_NUMBER, C_ALWAYS,    S_FETCH,    S_FETCH};
            S_SKIP:     w = '{OP_SKIP,   C_ALWAYS,    S_FETCH,    S_FETCH};
            S_TEXT:     w = '{OP_TEXT,   C_IS_LF,     S_AFTER_LF, S_FETCH};
            S_EMIT:     w = '{OP_EMIT,   C_EMIT_DONE, S_CLEAR,    S_EMIT};
            S_CLEAR:    w = '{OP_CLEAR,  C_ALWAYS,    S_FETCH,    S_FETCH};
            default:    w = '{OP_NONE,   C_ALWAYS,    S_FETCH,    S_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/smsnp_useq.sv =====
// ----------------------------------------------------------------------------
// smsnp_useq
// Step counter and microcode table lookup with conditional jumps.
// ----------------------------------------------------------------------------
module smsnp_useq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  smsnp_pkg::t_stat     i_stat,
    output smsnp_pkg::t_ctrl     o_ctrl
);

    logic [smsnp_pkg::STEP_W-1:0] r_step;
    logic [smsnp_pkg::STEP_W-1:0] n_step;
    smsnp_pkg::t_uword            w_uw;
    logic                         w_take;

    always_comb begin
        w_uw = smsnp_pkg::ucode_rom(r_step);
        unique case (w_uw.cond)
            smsnp_pkg::C_ALWAYS:    w_take = 1'b1;
            smsnp_pkg::C_IN_VALID:  w_take = i_in_valid;
            smsnp_pkg::C_PHASE:     w_take = 1'b1;
            smsnp_pkg::C_IS_LF:     w_take = i_stat.is_lf;
            smsnp_pkg::C_EMIT_DONE: w_take = i_stat.emit_done;
            default:                w_take = 1'b1;
        endcase
        if (w_uw.cond == smsnp_pkg::C_PHASE) begin
            // multiway jump on the parse phase
            n_step = w_uw.tgt_t + smsnp_pkg::STEP_W'(i_stat.phase);
        end else if (w_take) begin
            n_step = w_uw.tgt_t;
        end else begin
            n_step = w_uw.tgt_f;
        end
        o_ctrl.op     = w_uw.op;
        o_ctrl.accept = (w_uw.op == smsnp_pkg::OP_FETCH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= smsnp_pkg::S_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== sv/smsnp_dpath.sv =====
// ----------------------------------------------------------------------------
// smsnp_dpath
// Parse registers, number store and output register driven by the control word.
// ----------------------------------------------------------------------------
module smsnp_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smsnp_pkg::t_ctrl  i_ctrl,
    input  logic              i_in_valid,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_out_stall,
    output smsnp_pkg::t_stat  o_stat,
    output logic              o_out_valid,
    output logic [7:0]        o_phone_char,
    output logic [3:0]        o_char_index,
    output logic              o_is_command,
    output logic              o_last
);

    localparam int CW = smsnp_pkg::CNT_W;
    localparam int IW = smsnp_pkg::IDX_W;

    smsnp_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]     r_count, n_count;
    logic [7:0]        r_len, n_len;
    logic              r_match, n_match;
    logic              r_cmd, n_cmd;
    logic [3:0]        r_k, n_k;
    logic [7:0]        r_byte;
    logic [7:0]        r_store [smsnp_pkg::NUMBER_CHARS];

    logic              r_out_valid;
    logic [7:0]        r_phone_char;
    logic [3:0]        r_char_index;
    logic              r_is_command;
    logic              r_last;

    logic              w_is_lf;
    logic              w_slot_free;
    logic              w_store_we;
    logic              w_emit;
    logic [3:0]        w_rd_sum;

    assign w_is_lf     = (r_byte == smsnp_pkg::NL_BYTE);
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_emit      = (i_ctrl.op == smsnp_pkg::OP_EMIT) && w_slot_free;
    assign w_rd_sum    = 4'(smsnp_pkg::PREFIX_DROP) + r_k;

    assign o_stat.phase     = r_phase;
    assign o_stat.is_lf     = w_is_lf;
    assign o_stat.emit_done = w_emit && (r_k == smsnp_pkg::EMIT_LAST);

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_len      = r_len;
        n_match    = r_match;
        n_cmd      = r_cmd;
        n_k        = r_k;
        w_store_we = 1'b0;
        unique case (i_ctrl.op)
            smsnp_pkg::OP_WAIT: begin
                if (r_byte == smsnp_pkg::QUOTE) n_phase = smsnp_pkg::PH_NUMBER;
            end
            smsnp_pkg::OP_NUMBER: begin
                if (r_count < CW'(smsnp_pkg::NUMBER_CHARS)) begin
                    w_store_we = 1'b1;
                    n_count    = r_count + CW'(1);
                end else begin
                    n_phase = smsnp_pkg::PH_SKIP;
                end
            end
            smsnp_pkg::OP_SKIP: begin
                if (w_is_lf) n_phase = smsnp_pkg::PH_TEXT;
            end
            smsnp_pkg::OP_TEXT: begin
                if (w_is_lf) begin
                    n_cmd = r_match && (r_len == 8'd6);
                end else begin
                    if (r_len < 8'(smsnp_pkg::CMD_LEN) &&
                        r_byte != smsnp_pkg::CMD_WORD[r_len[2:0]]) begin
                        n_match = 1'b0;
                    end
                    if (r_len != 8'hFF) n_len = r_len + 8'd1;
                end
            end
            smsnp_pkg::OP_EMIT: begin
                if (w_slot_free) n_k = r_k + 4'd1;
            end
            smsnp_pkg::OP_CLEAR: begin
                n_phase = smsnp_pkg::PH_WAIT;
                n_count = '0;
                n_len   = '0;
                n_match = 1'b1;
                n_k     = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= smsnp_pkg::PH_WAIT;
            r_count     <= '0;
            r_len       <= '0;
            r_match     <= 1'b1;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_len   <= n_len;
            r_match <= n_match;
            r_k     <= n_k;
            if (w_slot_free) r_out_valid <= (i_ctrl.op == smsnp_pkg::OP_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (i_ctrl.accept && i_in_valid) r_byte <= i_rx_byte;
        if (w_store_we) r_store[r_count[IW-1:0]] <= r_byte;
        if (w_emit) begin
            r_phone_char <= r_store[w_rd_sum[IW-1:0]];
            r_char_index <= r_k;
            r_is_command <= r_cmd;
            r_last       <= (r_k == smsnp_pkg::EMIT_LAST);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_phone_char = r_phone_char;
    assign o_char_index = r_char_index;
    assign o_is_command = r_is_command;
    assign o_last       = r_last;

endmodule

// ===== sv/sms_notice_parser_top.sv =====
// ----------------------------------------------------------------------------
// sms_notice_parser_top
// Parses a modem new-message notice byte by byte and emits the sender number.
// ----------------------------------------------------------------------------
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+---------------------------------------
//  in      | i_in_valid  | o_in_stall   | i_rx_byte
//  out     | o_out_valid | i_out_stall  | o_phone_char, o_char_index,
//          |             |              | o_is_command, o_last
//
//  Each input beat runs three steps of the microcode program: fetch, phase
//  dispatch and one execute step; no new byte is taken before the next fetch.
//  The closing line feed adds one emit step per number character (ten here,
//  more while the output stalls) plus a clear step before the next fetch.
//  Reset (synchronous, active low) puts the step counter on fetch and the
//  parser in wait-for-quote; the number store is not cleared.
//  The emit step holds while the output register is full and stalled; input
//  is stalled during reset and at every step other than fetch.
//
module sms_notice_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_phone_char,
    output logic [3:0] o_char_index,
    output logic       o_is_command,
    output logic       o_last
);

    // control word from the sequencer, status back from the datapath
    smsnp_pkg::t_ctrl w_ctrl;
    smsnp_pkg::t_stat w_stat;

    smsnp_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    smsnp_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_in_valid   (i_in_valid),
        .i_rx_byte    (i_rx_byte),
        .i_out_stall  (i_out_stall),
        .o_stat       (w_stat),
        .o_out_valid  (o_out_valid),
        .o_phone_char (o_phone_char),
        .o_char_index (o_char_index),
        .o_is_command (o_is_command),
        .o_last       (o_last)
    );

    // input is only taken at the fetch step, never while in reset
    assign o_in_stall = !i_rst_n || !w_ctrl.accept;

    // a new result only appears after an emit step
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_ctrl.op == smsnp_pkg::OP_EMIT))
        else $error("output valid rose outside an emit step");

    // the last flag marks the final character position
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_char_index == smsnp_pkg::EMIT_LAST))
        else $error("last flag on wrong character index");

    // no input beat is taken while the number is being emitted
    a_no_accept_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == smsnp_pkg::OP_EMIT) |-> o_in_stall)
        else $error("input accepted during emit");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sms_notice_parser_top. A short table of directed
// beats is walked first, followed by randomly built modem notices (number,
// skipped header, message text, line feeds) mixed with line noise. A
// predictor tracks the parser state and queues the expected number
// characters. Every output beat is compared against that queue. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;  // well beyond the slowest legal run
    localparam int DRAIN_CYCLES = 40;      // covers the clear step after the last emit
    localparam int ITEM_BEATS   = 270;
    localparam int MIN_NOTICES  = 3;
    localparam int MAX_IDLE     = 17;
    localparam int LONG_TEXT    = 262;     // an 8-bit wrap would land on six
    localparam int REPORT_LIMIT = 10;

    // one expected output beat
    typedef struct {
        logic [7:0] ch;
        logic [3:0] idx;
        logic       cmd;
        logic       last;
    } t_exp_beat;

    // one row of the directed table; typed rows carry the command flag
    typedef struct {
        logic [7:0] rx;
        bit         typed;
        bit         cmd;
    } t_rx_row;

    typedef enum {
        K_TRACK,
        K_NEAR,
        K_EMPTY,
        K_RANDOM,
        K_LONG
    } t_notice_kind;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_rx_byte    = 8'h00;
    logic       i_out_stall  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_phone_char;
    logic [3:0] o_char_index;
    logic       o_is_command;
    logic       o_last;

    // predictor state
    smsnp_pkg::t_phase pred_phase;
    int                pred_count;
    logic [7:0]        pred_store [smsnp_pkg::NUMBER_CHARS];
    logic [7:0]        pred_length;
    logic              pred_match;

    t_exp_beat phone_chars_q [$];

    int fail_count  = 0;
    int cycle_count = 0;
    int beats_sent  = 0;

    // receiver idling state
    int hold_left   = 0;
    int mode_left   = 0;
    bit rcv_quiet   = 1'b0;

    // Directed beats: noise before the quote, a number holding the byte
    // extremes plus a quote and a line feed, a dropped quote, an immediate
    // line feed ending the skip, then "track" with a carriage return that
    // counts as a sixth text byte. The closing line feed must report a command.
    t_rx_row directed_tbl [25] = '{
        '{8'hFF, 1'b0, 1'b0},        // noise, ignored while waiting
        '{8'h00, 1'b0, 1'b0},
        '{smsnp_pkg::QUOTE, 1'b0, 1'b0},
        '{8'h2B, 1'b0, 1'b0},        // "+91" country code, not emitted
        '{8'h39, 1'b0, 1'b0},
        '{8'h31, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0},
        '{smsnp_pkg::QUOTE, 1'b0, 1'b0},
        '{smsnp_pkg::NL_BYTE, 1'b0, 1'b0},
        '{8'h35, 1'b0, 1'b0},
        '{8'h35, 1'b0, 1'b0},
        '{8'h35, 1'b0, 1'b0},
        '{8'h30, 1'b0, 1'b0},
        '{8'h31, 1'b0, 1'b0},
        '{8'h39, 1'b0, 1'b0},
        '{smsnp_pkg::QUOTE, 1'b0, 1'b0},      // dropped after the number
        '{smsnp_pkg::NL_BYTE, 1'b0, 1'b0},    // end of header line
        '{8'h74, 1'b0, 1'b0},
        '{8'h72, 1'b0, 1'b0},
        '{8'h61, 1'b0, 1'b0},
        '{8'h63, 1'b0, 1'b0},
        '{8'h6B, 1'b0, 1'b0},
        '{8'h0D, 1'b0, 1'b0},        // carriage return, sixth text byte before the closing line feed
        '{smsnp_pkg::NL_BYTE, 1'b1, 1'b1}
    };

    sms_notice_parser_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_phone_char (o_phone_char),
        .o_char_index (o_char_index),
        .o_is_command (o_is_command),
        .o_last       (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Count failures, print only the first few.
    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    task automatic clear_notice();
        pred_phase  = smsnp_pkg::PH_WAIT;
        pred_count  = 0;
        pred_length = 8'd0;
        pred_match  = 1'b1;
    endtask

    // Advance the parser model by one accepted byte and queue any number
    // characters released by a closing line feed.
    task automatic predict_notice_byte(input logic [7:0] rx, input bit typed,
                                       input bit cmd_typed);
        int        emit_n;
        t_exp_beat pc;
        emit_n = smsnp_pkg::NUMBER_CHARS - smsnp_pkg::PREFIX_DROP;
        if (emit_n < 0) emit_n = 0;
        if (emit_n > smsnp_pkg::MAX_EMIT) emit_n = smsnp_pkg::MAX_EMIT;
        unique case (pred_phase)
            smsnp_pkg::PH_WAIT: begin
                if (rx == smsnp_pkg::QUOTE) pred_phase = smsnp_pkg::PH_NUMBER;
            end
            smsnp_pkg::PH_NUMBER: begin
                if (pred_count < smsnp_pkg::NUMBER_CHARS) begin
                    pred_store[pred_count] = rx;
                    pred_count++;
                end else begin
                    pred_phase = smsnp_pkg::PH_SKIP;
                end
            end
            smsnp_pkg::PH_SKIP: begin
                if (rx == smsnp_pkg::NL_BYTE) pred_phase = smsnp_pkg::PH_TEXT;
            end
            default: begin
                if (rx == smsnp_pkg::NL_BYTE) begin
                    pc.cmd = pred_match && (pred_length == 8'd6);
                    if (typed) pc.cmd = cmd_typed;
                    for (int k = 0; k < emit_n; k++) begin
                        pc.ch   = pred_store[smsnp_pkg::PREFIX_DROP + k];
                        pc.idx  = 4'(k);
                        pc.last = (k == emit_n - 1);
                        phone_chars_q.push_back(pc);
                    end
                    clear_notice();
                end else begin
                    if (pred_length < 8'd5 &&
                        rx != smsnp_pkg::CMD_WORD[pred_length]) pred_match = 1'b0;
                    if (pred_length != 8'hFF) pred_length++;
                end
            end
        endcase
    endtask

    // Present one beat after an optional gap; hold it until accepted.
    task automatic send_beat(input logic [7:0] rx, input bit typed, input bit cmd,
                             input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= rx;
        do @(posedge i_clk); while (o_in_stall);
        predict_notice_byte(rx, typed, cmd);
        beats_sent++;
    endtask

    function automatic logic [7:0] any_but(input logic [7:0] banned);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == banned);
        return b;
    endfunction

    // Build one notice of the given kind, preceded by line noise, and send it.
    task automatic send_notice(input t_notice_kind kind);
        logic [7:0] body [$];
        bit         quiet;
        int         pos;
        int         n;
        quiet = ($urandom_range(0, 3) == 0);
        n = $urandom_range(0, 4);
        repeat (n) body.push_back(any_but(smsnp_pkg::QUOTE));
        body.push_back(smsnp_pkg::QUOTE);
        repeat (smsnp_pkg::NUMBER_CHARS) body.push_back(8'($urandom_range(0, 255)));
        body.push_back(8'($urandom_range(0, 255)));          // dropped
        n = $urandom_range(0, 3);
        repeat (n) body.push_back(any_but(smsnp_pkg::NL_BYTE));
        body.push_back(smsnp_pkg::NL_BYTE);
        case (kind)
            K_TRACK: begin
                for (int k = 0; k < smsnp_pkg::CMD_LEN; k++) begin
                    body.push_back(smsnp_pkg::CMD_WORD[k]);
                end
                body.push_back(any_but(smsnp_pkg::NL_BYTE));
            end
            K_NEAR: begin
                pos = $urandom_range(0, 2);
                for (int k = 0; k < smsnp_pkg::CMD_LEN; k++) begin
                    body.push_back(smsnp_pkg::CMD_WORD[k]);
                end
                if (pos == 0) begin
                    // spoil one letter, keep the length right
                    n = $urandom_range(0, smsnp_pkg::CMD_LEN - 1);
                    do body[body.size() - smsnp_pkg::CMD_LEN + n] =
                           any_but(smsnp_pkg::NL_BYTE);
                    while (body[body.size() - smsnp_pkg::CMD_LEN + n] ==
                           smsnp_pkg::CMD_WORD[n]);
                    body.push_back(any_but(smsnp_pkg::NL_BYTE));
                end else if (pos == 2) begin
                    body.push_back(any_but(smsnp_pkg::NL_BYTE));
                    body.push_back(any_but(smsnp_pkg::NL_BYTE));
                end
            end
            K_RANDOM: begin
                n = $urandom_range(0, 12);
                repeat (n) body.push_back(any_but(smsnp_pkg::NL_BYTE));
            end
            K_LONG: begin
                for (int k = 0; k < smsnp_pkg::CMD_LEN; k++) begin
                    body.push_back(smsnp_pkg::CMD_WORD[k]);
                end
                repeat (LONG_TEXT - smsnp_pkg::CMD_LEN) begin
                    body.push_back(any_but(smsnp_pkg::NL_BYTE));
                end
            end
            default: ;
        endcase
        body.push_back(smsnp_pkg::NL_BYTE);
        foreach (body[i]) begin
            send_beat(body[i], 1'b0, 1'b0, quiet ? 0 : $urandom_range(0, MAX_IDLE));
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: check each accepted beat against the oldest expectation,
    // then draw how long to stall before the next one. The receiver switches
    // between runs of random stalls and runs with no stalls at all.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_exp_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (phone_chars_q.size() == 0) begin
                note_failure($sformatf("unexpected beat char=%02h idx=%0d cmd=%0b last=%0b",
                                       o_phone_char, o_char_index, o_is_command, o_last));
            end else begin
                want = phone_chars_q.pop_front();
                if (o_phone_char !== want.ch || o_char_index !== want.idx ||
                    o_is_command !== want.cmd || o_last !== want.last) begin
                    note_failure($sformatf(
                        "mismatch exp ch=%02h i=%0d c=%0b l=%0b, got ch=%02h i=%0d c=%0b l=%0b",
                        want.ch, want.idx, want.cmd, want.last,
                        o_phone_char, o_char_index, o_is_command, o_last));
                end
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(5, 30);
                rcv_quiet = ($urandom_range(0, 2) == 0);
            end
            mode_left--;
            hold_left = rcv_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        end else if (hold_left > 0) begin
            hold_left--;
        end
        i_out_stall <= (hold_left != 0);
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed table, forced special notices, then random
    // notices until enough beats and notices have gone in. The saturating-length
    // notice alone exceeds the beat budget.
    // ------------------------------------------------------------------------
    initial begin
        int           notices;
        int           pick;
        t_notice_kind kind;
        clear_notice();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_tbl[i]) begin
            send_beat(directed_tbl[i].rx, directed_tbl[i].typed, directed_tbl[i].cmd,
                      $urandom_range(0, MAX_IDLE));
        end

        // Cover saturating length and empty text first.
        send_notice(K_LONG);
        send_notice(K_EMPTY);
        notices = 2;

        while (beats_sent < ITEM_BEATS || notices < MIN_NOTICES) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)      kind = K_TRACK;
            else if (pick < 55) kind = K_NEAR;
            else if (pick < 65) kind = K_EMPTY;
            else                kind = K_RANDOM;
            send_notice(kind);
            notices++;
        end
        i_in_valid <= 1'b0;

        // Drain every expected character, then let the clear step pass.
        while (phone_chars_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sms_notice_parser_top.f =====
sv/smsnp_pkg.sv
sv/smsnp_useq.sv
sv/smsnp_dpath.sv
sv/sms_notice_parser_top.sv
sim/testbench.sv
